>>> hw/rtl/cmfd_pkg.sv
// Package with shared constants and types for the mixer/decimator.
package cmfd_pkg;

  localparam int MAX_TAPS_DEF    = 128;
  localparam int MAX_DECIM_DEF   = 64;
  localparam int SAMPLE_BITS_DEF = 16;
  localparam int COEF_BITS_DEF   = 18;
  localparam int OSC_FRAC        = 30;

  localparam logic [2:0] REG_MIX_ENABLE   = 3'd0;
  localparam logic [2:0] REG_PHASE_COS    = 3'd1;
  localparam logic [2:0] REG_PHASE_SIN    = 3'd2;
  localparam logic [2:0] REG_DECIM_FACTOR = 3'd3;
  localparam logic [2:0] REG_TAP_COUNT    = 3'd4;

  localparam logic CMD_SAMPLE = 1'b0;
  localparam logic CMD_LOAD   = 1'b1;

  typedef enum logic [2:0] {
    DP_IDLE = 3'd0,
    DP_MIX  = 3'd1,
    DP_OSC  = 3'd2,
    DP_MAC  = 3'd3,
    DP_FIN  = 3'd4,
    DP_SHIFT = 3'd5,
    DP_LOAD = 3'd6
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
    logic   step;
  } dp_cmd_t;

  typedef struct packed {
    logic mix_en;
    logic last;
    logic ready_out;
  } dp_stat_t;

endpackage

>>> hw/rtl/complex_mixer_fir_decimator_core.sv
// Top level of the complex mixer with decimating FIR filter.
//   channel | direction | handshake             | payload
//   in_     | input     | in_valid / in_ready   | command, i, q, coef_index, coef_value
//   out_    | output    | out_valid / out_ready | i, q
//   cfg_    | input     | cfg_we                | cfg_index, cfg_data
// A load transaction is taken in S_IDLE; a sample passes S_FIN and S_CHK, with S_MIX and S_OSC first when mixing.
// A sample that completes an output then runs the shared MAC in S_MAC, followed by S_SHIFT.
// Reset is synchronous and sets control and configuration registers to their defaults.
// A finished output waits in the output register; the next output stalls behind it.
module complex_mixer_fir_decimator_core
  import cmfd_pkg::*;
#(
  parameter int MAX_TAPS    = MAX_TAPS_DEF,
  parameter int MAX_DECIM   = MAX_DECIM_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
  parameter int COEF_BITS   = COEF_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [2:0]                    cfg_index,
  input  logic [31:0]                   cfg_data,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          in_command,
  input  logic signed [SAMPLE_BITS-1:0] in_i,
  input  logic signed [SAMPLE_BITS-1:0] in_q,
  input  logic [6:0]                    in_coef_index,
  input  logic signed [COEF_BITS-1:0]   in_coef_value,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [SAMPLE_BITS-1:0] out_i,
  output logic signed [SAMPLE_BITS-1:0] out_q
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  cmfd_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_command(in_command),
    .in_ready(in_ready), .out_valid(out_valid), .out_ready(out_ready),
    .stat(stat), .cmd(cmd)
  );

  cmfd_datapath #(
    .MAX_TAPS(MAX_TAPS), .MAX_DECIM(MAX_DECIM),
    .SAMPLE_BITS(SAMPLE_BITS), .COEF_BITS(COEF_BITS)
  ) u_dp (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .in_i(in_i), .in_q(in_q),
    .in_coef_index(in_coef_index), .in_coef_value(in_coef_value),
    .cmd(cmd), .stat(stat), .out_i(out_i), .out_q(out_q)
  );

endmodule

>>> hw/rtl/cmfd_datapath.sv
// Datapath: oscillator, mixer, history memory, coefficient memory and shared MAC.
module cmfd_datapath
  import cmfd_pkg::*;
#(
  parameter int MAX_TAPS    = MAX_TAPS_DEF,
  parameter int MAX_DECIM   = MAX_DECIM_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
  parameter int COEF_BITS   = COEF_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [2:0]                    cfg_index,
  input  logic [31:0]                   cfg_data,
  input  logic signed [SAMPLE_BITS-1:0] in_i,
  input  logic signed [SAMPLE_BITS-1:0] in_q,
  input  logic [6:0]                    in_coef_index,
  input  logic signed [COEF_BITS-1:0]   in_coef_value,
  input  dp_cmd_t                       cmd,
  output dp_stat_t                      stat,
  output logic signed [SAMPLE_BITS-1:0] out_i,
  output logic signed [SAMPLE_BITS-1:0] out_q
);

  localparam int HD = MAX_TAPS + MAX_DECIM;
  localparam int AW = $clog2(HD);
  localparam int CW = $clog2(MAX_TAPS);
  localparam int FW = $clog2(HD + 1);
  localparam int TW = $clog2(MAX_TAPS + 1);
  localparam int DW = $clog2(MAX_DECIM + 1);
  localparam int PW = SAMPLE_BITS + COEF_BITS;
  localparam int ACCW = PW + AW + 1;
  localparam int COEF_FRAC = COEF_BITS - 2;
  localparam logic [FW-1:0] HD_M1 = FW'(HD - 1);
  localparam logic signed [SAMPLE_BITS-1:0] SMAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic signed [SAMPLE_BITS-1:0] SMIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

  logic mix_en_r;
  logic signed [31:0] pcos_r, psin_r, osc_re_r, osc_im_r;
  logic [6:0] decim_r;
  logic [7:0] taps_r;

  logic signed [SAMPLE_BITS-1:0] hist_i [HD];
  logic signed [SAMPLE_BITS-1:0] hist_q [HD];
  logic signed [COEF_BITS-1:0]   coef_mem [MAX_TAPS];

  // History is a ring: base_r marks the oldest entry.
  logic [AW-1:0] base_r;
  logic [FW-1:0] fill_r;
  logic [TW-1:0] k_r;

  logic signed [SAMPLE_BITS-1:0] si_r, sq_r;
  logic signed [63:0] p0_r, p1_r, p2_r, p3_r;
  logic signed [SAMPLE_BITS-1:0] hi_rd_r, hq_rd_r;
  logic signed [COEF_BITS-1:0]   c_rd_r;
  logic rd_v_r;
  logic signed [ACCW-1:0] acc_i_r, acc_q_r;
  logic signed [SAMPLE_BITS-1:0] oi_r, oq_r;

  logic [TW-1:0] t_eff;
  logic [DW-1:0] d_eff;
  logic [FW:0]   need;

  always_comb begin
    if (taps_r == 8'd0) t_eff = TW'(1);
    else if (32'(taps_r) > MAX_TAPS) t_eff = TW'(MAX_TAPS);
    else t_eff = TW'(taps_r);
    if (decim_r == 7'd0) d_eff = DW'(1);
    else if (32'(decim_r) > MAX_DECIM) d_eff = DW'(MAX_DECIM);
    else d_eff = DW'(decim_r);
    need = (FW+1)'(t_eff) + (FW+1)'(d_eff);
  end

  function automatic logic signed [63:0] rnd30(input logic signed [63:0] a,
                                               input logic signed [63:0] b);
    logic signed [65:0] s;
    begin
      s = 66'(a) + 66'(b) + 66'(64'sd1 <<< (OSC_FRAC - 1));
      rnd30 = 64'(s >>> OSC_FRAC);
    end
  endfunction

  function automatic logic signed [SAMPLE_BITS-1:0] sat_s(input logic signed [63:0] v);
    begin
      if (v > 64'(SMAX)) sat_s = SMAX;
      else if (v < 64'(SMIN)) sat_s = SMIN;
      else sat_s = v[SAMPLE_BITS-1:0];
    end
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    begin
      if (v > 64'sd2147483647) sat32 = 32'sh7fffffff;
      else if (v < -64'sd2147483648) sat32 = 32'sh80000000;
      else sat32 = v[31:0];
    end
  endfunction

  logic [AW-1:0] wr_addr, rd_addr;
  logic [AW:0]   wr_sum, rd_sum, base_sum;
  logic [FW-1:0] fill_clamp;

  always_comb begin
    fill_clamp = (fill_r >= FW'(HD)) ? HD_M1 : fill_r;
    wr_sum = (AW+1)'(base_r) + (AW+1)'(fill_clamp);
    wr_addr = (wr_sum >= (AW+1)'(HD)) ? AW'(wr_sum - (AW+1)'(HD)) : AW'(wr_sum);
    rd_sum = (AW+1)'(base_r) + (AW+1)'(k_r);
    rd_addr = (rd_sum >= (AW+1)'(HD)) ? AW'(rd_sum - (AW+1)'(HD)) : AW'(rd_sum);
    base_sum = (AW+1)'(base_r) + (AW+1)'(d_eff);
    stat.mix_en    = mix_en_r;
    stat.last      = (k_r == t_eff) && !rd_v_r;
    stat.ready_out = ((FW+1)'(fill_r) >= need);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mix_en_r <= 1'b0;
      pcos_r   <= 32'sd1073741824;
      psin_r   <= '0;
      osc_re_r <= 32'sd1073741824;
      osc_im_r <= '0;
      decim_r  <= 7'd1;
      taps_r   <= 8'd1;
      base_r   <= '0;
      fill_r   <= '0;
      k_r      <= '0;
      rd_v_r   <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_MIX_ENABLE:   mix_en_r <= cfg_data[0];
          REG_PHASE_COS: begin
            pcos_r   <= cfg_data;
            osc_re_r <= 32'sd1073741824;
            osc_im_r <= '0;
          end
          REG_PHASE_SIN:    psin_r <= cfg_data;
          REG_DECIM_FACTOR: decim_r <= cfg_data[6:0];
          REG_TAP_COUNT:    taps_r <= cfg_data[7:0];
          default: ;
        endcase
      end
      if (cmd.step) begin
        unique case (cmd.op)
          DP_IDLE: begin
            si_r <= in_i;
            sq_r <= in_q;
            p0_r <= 64'(in_i) * 64'(osc_re_r);
            p1_r <= -(64'(in_q) * 64'(osc_im_r));
            p2_r <= 64'(in_i) * 64'(osc_im_r);
            p3_r <= 64'(in_q) * 64'(osc_re_r);
          end
          DP_MIX: begin
            si_r <= sat_s(rnd30(p0_r, p1_r));
            sq_r <= sat_s(rnd30(p2_r, p3_r));
            p0_r <= 64'(osc_re_r) * 64'(pcos_r);
            p1_r <= -(64'(osc_im_r) * 64'(psin_r));
            p2_r <= 64'(osc_re_r) * 64'(psin_r);
            p3_r <= 64'(osc_im_r) * 64'(pcos_r);
          end
          DP_OSC: begin
            osc_re_r <= sat32(rnd30(p0_r, p1_r));
            osc_im_r <= sat32(rnd30(p2_r, p3_r));
          end
          DP_LOAD: begin
            if (32'(in_coef_index) < MAX_TAPS) coef_mem[CW'(in_coef_index)] <= in_coef_value;
          end
          DP_FIN: begin
            hist_i[wr_addr] <= si_r;
            hist_q[wr_addr] <= sq_r;
            fill_r <= fill_clamp + FW'(1);
            k_r <= '0;
            rd_v_r <= 1'b0;
            acc_i_r <= '0;
            acc_q_r <= '0;
          end
          DP_MAC: begin
            if (k_r != t_eff) begin
              hi_rd_r <= hist_i[rd_addr];
              hq_rd_r <= hist_q[rd_addr];
              c_rd_r  <= coef_mem[CW'(k_r)];
              k_r <= k_r + TW'(1);
            end
            rd_v_r <= (k_r != t_eff);
            if (rd_v_r) begin
              acc_i_r <= acc_i_r + ACCW'(hi_rd_r * c_rd_r);
              acc_q_r <= acc_q_r + ACCW'(hq_rd_r * c_rd_r);
            end
          end
          DP_SHIFT: begin
            oi_r <= sat_s(64'((acc_i_r + ACCW'(1 <<< (COEF_FRAC - 1))) >>> COEF_FRAC));
            oq_r <= sat_s(64'((acc_q_r + ACCW'(1 <<< (COEF_FRAC - 1))) >>> COEF_FRAC));
            base_r <= (base_sum >= (AW+1)'(HD)) ? AW'(base_sum - (AW+1)'(HD)) : AW'(base_sum);
            fill_r <= fill_r - FW'(d_eff);
          end
          default: ;
        endcase
      end
    end
  end

  assign out_i = oi_r;
  assign out_q = oq_r;

endmodule

>>> hw/rtl/cmfd_ctrl.sv
// Controller state machine sequencing one transaction through the datapath.
module cmfd_ctrl
  import cmfd_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  input  logic     in_command,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_MIX   = 7'b0000010,
    S_OSC   = 7'b0000100,
    S_FIN   = 7'b0001000,
    S_CHK   = 7'b0010000,
    S_MAC   = 7'b0100000,
    S_SHIFT = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;
  logic ov_r, ov_nxt;

  always_comb begin
    state_nxt = state_r;
    ov_nxt = ov_r;
    cmd.op = DP_IDLE;
    cmd.step = 1'b0;
    in_ready = 1'b0;
    if (ov_r && out_ready) ov_nxt = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.step = 1'b1;
          if (in_command == CMD_LOAD) cmd.op = DP_LOAD;
          else begin
            cmd.op = DP_IDLE;
            state_nxt = stat.mix_en ? S_MIX : S_FIN;
          end
        end
      end
      S_MIX: begin
        cmd.op = DP_MIX; cmd.step = 1'b1; state_nxt = S_OSC;
      end
      S_OSC: begin
        cmd.op = DP_OSC; cmd.step = 1'b1; state_nxt = S_FIN;
      end
      S_FIN: begin
        cmd.op = DP_FIN; cmd.step = 1'b1; state_nxt = S_CHK;
      end
      S_CHK: begin
        state_nxt = stat.ready_out ? S_MAC : S_IDLE;
      end
      S_MAC: begin
        cmd.op = DP_MAC; cmd.step = 1'b1;
        if (stat.last) state_nxt = S_SHIFT;
      end
      S_SHIFT: begin
        if (!ov_r || out_ready) begin
          cmd.op = DP_SHIFT; cmd.step = 1'b1;
          ov_nxt = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ov_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ov_r <= ov_nxt;
    end
  end

  assign out_valid = ov_r;

endmodule
